@@ src/one_wire_temperature_reader_core_assert.svh @@
// Assertion macros shared by the one-wire reader modules.
`ifndef ONE_WIRE_TEMPERATURE_READER_CORE_ASSERT_SVH
`define ONE_WIRE_TEMPERATURE_READER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define OWTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OWTR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/owtr_pkg.sv @@
package owtr_pkg;

  localparam int TIMER_BITS = 20;
  localparam int WAIT_BITS  = 20;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  localparam logic [WAIT_BITS-1:0] WAIT_RESET = WAIT_BITS'(750000);

  // Slot timing in microsecond ticks.
  localparam logic [TIMER_BITS-1:0] T_RST_LAST    = TIMER_BITS'(479);
  localparam logic [TIMER_BITS-1:0] T_PRESENCE    = TIMER_BITS'(70);
  localparam logic [TIMER_BITS-1:0] T_SLOT_LAST   = TIMER_BITS'(69);
  localparam logic [TIMER_BITS-1:0] T_LOW_ONE     = TIMER_BITS'(6);
  localparam logic [TIMER_BITS-1:0] T_LOW_ZERO    = TIMER_BITS'(60);
  localparam logic [TIMER_BITS-1:0] T_READ_SAMPLE = TIMER_BITS'(15);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_RST_LOW = 6'b000010,
    PH_RST_REL = 6'b000100,
    PH_WRITE   = 6'b001000,
    PH_WAIT    = 6'b010000,
    PH_READ    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        drive_low;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] temperature_fixed;
  } result_t;

endpackage

@@ src/one_wire_temperature_reader_core.sv @@
// One-wire temperature reader: one result per accepted tick or start request.
// An input transaction passes through the input register, then the sequencer
// step into the result register. Throughput: one item per cycle while the
// receiver takes results; a two-entry result queue keeps input flowing while a
// result waits. Reset (rst_n low, synchronous) returns the sequencer to idle,
// empties the pipeline and sets the conversion wait to 750000 ticks.
module one_wire_temperature_reader_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] line_level, [7:1] zero
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] drive_low, [2:1] status, [18:3] temperature_fixed,
                                  // [30:19] temperature_whole, [31] zero
  output logic        out_tlast,  // done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data    // conversion_wait_us
);

  logic [owtr_pkg::WAIT_BITS-1:0] conv_wait_r;
  logic                           in_valid_r;
  logic                           in_op_r;
  logic                           in_level_r;
  logic                           stage_fire;
  owtr_pkg::result_t              res;
  owtr_pkg::result_t              out_data_r;
  owtr_pkg::result_t              skid_data_r;
  logic                           out_valid_r;
  logic                           skid_valid_r;
  logic                           pop;

  assign cfg_ready  = 1'b1;
  assign pop        = out_valid_r && out_tready;
  assign stage_fire = in_valid_r && (!skid_valid_r || out_tready);
  assign in_tready  = !in_valid_r || stage_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_wait_r <= owtr_pkg::WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      conv_wait_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_op_r    <= in_tuser;
      in_level_r <= in_tdata[0];
    end
  end

  owtr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (stage_fire),
    .op        (in_op_r),
    .level     (in_level_r),
    .conv_wait (conv_wait_r),
    .res       (res)
  );

  // Result queue: the head drives the port, the skid entry catches a result
  // produced while the head is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= stage_fire;
      end else begin
        out_valid_r <= stage_fire;
      end
    end else if (stage_fire) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end else if (stage_fire) begin
      if (out_valid_r) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_data_r.done_res;
  assign out_tdata  = {1'b0, out_data_r.temperature_fixed[15:4],
                       out_data_r.temperature_fixed, out_data_r.status,
                       out_data_r.drive_low};

`include "one_wire_temperature_reader_core_assert.svh"

  `OWTR_ASSERT(a_skid_needs_head, skid_valid_r |-> out_valid_r, "skid entry holds a result while the head is empty")
  `OWTR_ASSERT(a_stage_holds, (in_valid_r && !stage_fire) |=> in_valid_r, "stalled input item was lost")
  `OWTR_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_valid_r && !skid_valid_r && !in_valid_r), "pipeline not empty after reset")

endmodule

@@ src/owtr_seq.sv @@
module owtr_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  logic                              op,
  input  logic                              level,
  input  logic [owtr_pkg::WAIT_BITS-1:0]    conv_wait,
  output owtr_pkg::result_t                 res
);

  owtr_pkg::phase_t                 phase_r, phase_nxt;
  logic [owtr_pkg::TIMER_BITS-1:0]  timer_r, timer_nxt, timer_inc;
  logic [3:0]                       bit_count_r, bit_count_nxt;
  logic                             cmd_sel_r, cmd_sel_nxt;
  logic [15:0]                      shift_r, shift_nxt;
  logic                             second_r, second_nxt;
  logic                             absent_r, absent_nxt;
  logic [7:0]                       wr_byte;
  logic                             wr_bit;
  logic                             drive_now;

  always_comb begin
    wr_byte   = !cmd_sel_r ? owtr_pkg::CMD_SKIP_ROM :
                (second_r ? owtr_pkg::CMD_READ_SP : owtr_pkg::CMD_CONVERT);
    wr_bit    = wr_byte[bit_count_r[2:0]];
    timer_inc = timer_r + 1'b1;

    case (phase_r)
      owtr_pkg::PH_RST_LOW: drive_now = 1'b1;
      owtr_pkg::PH_WRITE:   drive_now = timer_r < (wr_bit ? owtr_pkg::T_LOW_ONE
                                                          : owtr_pkg::T_LOW_ZERO);
      owtr_pkg::PH_READ:    drive_now = timer_r < owtr_pkg::T_LOW_ONE;
      default:              drive_now = 1'b0;
    endcase

    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    bit_count_nxt = bit_count_r;
    cmd_sel_nxt   = cmd_sel_r;
    shift_nxt     = shift_r;
    second_nxt    = second_r;
    absent_nxt    = absent_r;
    res           = '0;
    res.drive_low = drive_now;

    if (op == owtr_pkg::OP_START) begin
      // A start request while a read is under way is ignored and takes no time.
      if (phase_r == owtr_pkg::PH_IDLE) begin
        second_nxt    = 1'b0;
        cmd_sel_nxt   = 1'b0;
        bit_count_nxt = '0;
        shift_nxt     = '0;
        absent_nxt    = 1'b0;
        phase_nxt     = owtr_pkg::PH_RST_LOW;
        timer_nxt     = '0;
        res.drive_low = 1'b1;
      end
    end else begin
      case (phase_r)
        owtr_pkg::PH_RST_LOW: begin
          if (timer_r >= owtr_pkg::T_RST_LAST) begin
            phase_nxt = owtr_pkg::PH_RST_REL;
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_inc;
          end
        end
        owtr_pkg::PH_RST_REL: begin
          if (timer_r == owtr_pkg::T_PRESENCE) begin
            absent_nxt = level;
          end
          if (timer_r >= owtr_pkg::T_RST_LAST) begin
            timer_nxt = '0;
            if (absent_nxt) begin
              res.done_res = 1'b1;
              res.status   = owtr_pkg::ST_ABSENT;
              phase_nxt    = owtr_pkg::PH_IDLE;
            end else begin
              cmd_sel_nxt   = 1'b0;
              bit_count_nxt = '0;
              phase_nxt     = owtr_pkg::PH_WRITE;
            end
          end else begin
            timer_nxt = timer_inc;
          end
        end
        owtr_pkg::PH_WRITE: begin
          if (timer_r >= owtr_pkg::T_SLOT_LAST) begin
            bit_count_nxt = {1'b0, bit_count_r[2:0] + 3'd1};
            timer_nxt     = '0;
            if (bit_count_r[2:0] == 3'd7) begin
              if (!cmd_sel_r) begin
                cmd_sel_nxt = 1'b1;
              end else if (second_r) begin
                bit_count_nxt = '0;
                shift_nxt     = '0;
                phase_nxt     = owtr_pkg::PH_READ;
              end else begin
                second_nxt = 1'b1;
                phase_nxt  = (conv_wait == '0) ? owtr_pkg::PH_RST_LOW : owtr_pkg::PH_WAIT;
              end
            end
          end else begin
            timer_nxt = timer_inc;
          end
        end
        owtr_pkg::PH_WAIT: begin
          if (timer_inc >= conv_wait) begin
            phase_nxt = owtr_pkg::PH_RST_LOW;
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_inc;
          end
        end
        owtr_pkg::PH_READ: begin
          if (timer_r == owtr_pkg::T_READ_SAMPLE) begin
            shift_nxt = {level, shift_r[15:1]};
          end
          if (timer_r >= owtr_pkg::T_SLOT_LAST) begin
            timer_nxt = '0;
            if (bit_count_r == 4'd15) begin
              res.done_res          = 1'b1;
              res.status            = owtr_pkg::ST_OK;
              res.temperature_fixed = shift_nxt;
              bit_count_nxt         = '0;
              phase_nxt             = owtr_pkg::PH_IDLE;
            end else begin
              bit_count_nxt = bit_count_r + 4'd1;
            end
          end else begin
            timer_nxt = timer_inc;
          end
        end
        default: begin
          phase_nxt = owtr_pkg::PH_IDLE;
          timer_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owtr_pkg::PH_IDLE;
      timer_r     <= '0;
      bit_count_r <= '0;
      cmd_sel_r   <= 1'b0;
      shift_r     <= '0;
      second_r    <= 1'b0;
      absent_r    <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      bit_count_r <= bit_count_nxt;
      cmd_sel_r   <= cmd_sel_nxt;
      shift_r     <= shift_nxt;
      second_r    <= second_nxt;
      absent_r    <= absent_nxt;
    end
  end

`include "one_wire_temperature_reader_core_assert.svh"

  `OWTR_ASSERT(a_wait_after_convert, (phase_r == owtr_pkg::PH_WAIT) |-> (second_r && cmd_sel_r), "conversion wait entered before the convert command")
  `OWTR_ASSERT(a_read_after_command, (phase_r == owtr_pkg::PH_READ) |-> (second_r && cmd_sel_r), "data read entered before the read-scratchpad command")
  `OWTR_ASSERT(a_done_has_status, (fire && res.done_res) |-> (res.status != owtr_pkg::ST_BUSY), "finished read reported without a status")

endmodule

@@ bench/owtr_read_checker.sv @@
module owtr_read_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] line_level, [7:1] zero
  input  logic        in_tuser,   // [0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [0] drive_low, [2:1] status, [18:3] temperature_fixed,
                                  // [30:19] temperature_whole, [31] zero
  input  logic        out_tlast,  // done_res
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [19:0] cfg_data,   // conversion_wait_us
  output int          n_failures,
  output int          n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        drive_low;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] temp_fixed;
    logic [11:0] temp_whole;
  } reading_t;

  // Own copy of the bus master's state.
  owtr_pkg::phase_t                phase;
  logic [owtr_pkg::TIMER_BITS-1:0] timer;
  logic [3:0]                      bit_cnt;
  logic                            cmd_idx;
  logic [15:0]                     rd_shift;
  logic                            second_pass;
  logic                            absent;
  logic [owtr_pkg::WAIT_BITS-1:0]  wait_us;

  reading_t expected_readings[$];

  initial n_failures = 0;
  initial n_pending = 0;

  function automatic logic bus_drive_now();
    logic [7:0] cmd;
    cmd = !cmd_idx ? owtr_pkg::CMD_SKIP_ROM
                   : (second_pass ? owtr_pkg::CMD_READ_SP : owtr_pkg::CMD_CONVERT);
    case (phase)
      owtr_pkg::PH_RST_LOW: return 1'b1;
      owtr_pkg::PH_WRITE:   return timer < (cmd[bit_cnt[2:0]] ? owtr_pkg::T_LOW_ONE
                                                             : owtr_pkg::T_LOW_ZERO);
      owtr_pkg::PH_READ:    return timer < owtr_pkg::T_LOW_ONE;
      default:              return 1'b0;
    endcase
  endfunction

  // One accepted transaction through the sequencer: a tick advances bus time,
  // a start only matters while idle.
  task automatic advance_bus_master(input logic op, input logic lvl, output reading_t r);
    logic [15:0] raw;
    logic        last_bit;
    r   = '0;
    raw = '0;
    if (op == owtr_pkg::OP_START) begin
      if (phase == owtr_pkg::PH_IDLE) begin
        second_pass = 1'b0;
        cmd_idx     = 1'b0;
        bit_cnt     = '0;
        rd_shift    = '0;
        absent      = 1'b0;
        phase       = owtr_pkg::PH_RST_LOW;
        timer       = '0;
      end
      r.drive_low = bus_drive_now();
    end else begin
      r.drive_low = bus_drive_now();
      case (phase)
        owtr_pkg::PH_RST_LOW: begin
          if (timer >= owtr_pkg::T_RST_LAST) begin
            phase = owtr_pkg::PH_RST_REL;
            timer = '0;
          end else begin
            timer++;
          end
        end
        owtr_pkg::PH_RST_REL: begin
          if (timer == owtr_pkg::T_PRESENCE) absent = lvl;
          if (timer >= owtr_pkg::T_RST_LAST) begin
            if (absent) begin
              r.done_res = 1'b1;
              r.status   = owtr_pkg::ST_ABSENT;
              phase      = owtr_pkg::PH_IDLE;
            end else begin
              cmd_idx = 1'b0;
              bit_cnt = '0;
              phase   = owtr_pkg::PH_WRITE;
            end
            timer = '0;
          end else begin
            timer++;
          end
        end
        owtr_pkg::PH_WRITE: begin
          if (timer >= owtr_pkg::T_SLOT_LAST) begin
            last_bit = (bit_cnt[2:0] == 3'd7);
            bit_cnt  = {1'b0, bit_cnt[2:0] + 3'd1};
            timer    = '0;
            if (last_bit) begin
              if (!cmd_idx) begin
                cmd_idx = 1'b1;
              end else if (second_pass) begin
                bit_cnt  = '0;
                rd_shift = '0;
                phase    = owtr_pkg::PH_READ;
              end else begin
                second_pass = 1'b1;
                phase       = (wait_us == '0) ? owtr_pkg::PH_RST_LOW : owtr_pkg::PH_WAIT;
              end
            end
          end else begin
            timer++;
          end
        end
        owtr_pkg::PH_WAIT: begin
          timer++;
          if (timer >= wait_us) begin
            phase = owtr_pkg::PH_RST_LOW;
            timer = '0;
          end
        end
        owtr_pkg::PH_READ: begin
          if (timer == owtr_pkg::T_READ_SAMPLE) rd_shift = {lvl, rd_shift[15:1]};
          if (timer >= owtr_pkg::T_SLOT_LAST) begin
            timer = '0;
            if (bit_cnt == 4'hF) begin
              r.done_res = 1'b1;
              r.status   = owtr_pkg::ST_OK;
              raw        = rd_shift;
              bit_cnt    = '0;
              phase      = owtr_pkg::PH_IDLE;
            end else begin
              bit_cnt++;
            end
          end else begin
            timer++;
          end
        end
        default: begin
          phase = owtr_pkg::PH_IDLE;
          timer = '0;
        end
      endcase
    end
    r.temp_fixed = raw;
    r.temp_whole = raw[15:4];
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_failures++;
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    reading_t next;
    if (!rst_n) begin
      phase       = owtr_pkg::PH_IDLE;
      timer       = '0;
      bit_cnt     = '0;
      cmd_idx     = 1'b0;
      rd_shift    = '0;
      second_pass = 1'b0;
      absent      = 1'b0;
      wait_us     = owtr_pkg::WAIT_RESET;
      expected_readings.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_readings.size() == 0) begin
          $error("result transaction 0x%0h with nothing expected", out_tdata);
          n_failures++;
        end else begin
          want = expected_readings.pop_front();
          check_field("drive_low", 16'(want.drive_low), 16'(out_tdata[0]));
          check_field("done_res", 16'(want.done_res), 16'(out_tlast));
          check_field("status", 16'(want.status), 16'(out_tdata[2:1]));
          check_field("temperature_fixed", want.temp_fixed, out_tdata[18:3]);
          check_field("temperature_whole", 16'(want.temp_whole), 16'(out_tdata[30:19]));
          check_field("pad", 16'd0, 16'(out_tdata[31]));
        end
      end
      if (cfg_valid && cfg_ready) wait_us = cfg_data;
      if (in_tvalid && in_tready) begin
        advance_bus_master(in_tuser, in_tdata[0], next);
        expected_readings.push_back(next);
      end
    end
    n_pending <= expected_readings.size();
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_WAIT    = 1048575;

  // Receiver behaviour codes.
  localparam int READY_ALWAYS = 0;
  localparam int READY_RANDOM = 1;
  localparam int READY_RUNS   = 2;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] line_level, [7:1] zero
  logic        in_tuser;   // [0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [0] drive_low, [2:1] status, [18:3] temperature_fixed,
                           // [30:19] temperature_whole, [31] zero
  logic        out_tlast;  // done_res
  logic        cfg_valid;
  logic        cfg_ready;
  logic [19:0] cfg_data;   // conversion_wait_us

  int n_failures;
  int n_pending;
  int burst_left   = 0;
  int conv_wait    = 750000;
  int quiet_cycles = 0;
  int ready_mode   = READY_ALWAYS;
  int mode_left    = 0;
  int run_left     = 0;
  logic run_ready  = 1'b1;

  always #5 clk = ~clk;

  one_wire_temperature_reader_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  owtr_read_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .n_failures (n_failures),
    .n_pending  (n_pending)
  );

  // The receiver switches between always ready, random stalls and runs of stalls.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(READY_ALWAYS, READY_RUNS);
      mode_left  = $urandom_range(40, 800);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
      default: begin
        if (run_left == 0) begin
          run_ready = !run_ready;
          run_left  = $urandom_range(1, 12);
        end else begin
          run_left--;
        end
        out_tready <= run_ready;
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transaction; the sender pauses between bursts of random length.
  task automatic send_item(input logic op, input logic lvl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(500, 3000)
                                               : $urandom_range(1, 60);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (n_pending != 0);
    // Idle ticks give no completion, so let the pipeline settle as well.
    repeat (4) @(posedge clk);
  endtask

  task automatic set_conversion_wait(input int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= 20'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    conv_wait = value;
  endtask

  // A complete read as seen from the bus: the device answers each presence
  // check as asked and offers the given temperature in the read slots. Other
  // ticks carry random levels, and the odd start while busy is thrown in.
  task automatic drive_temperature_read(input logic present_a, input logic present_b,
                                        input logic [15:0] temp);
    int   n_ticks;
    int   second_rst;
    int   read_from;
    logic lvl;
    second_rst = 2080 + conv_wait;
    read_from  = second_rst + 2080;
    n_ticks = !present_a ? 960 : (!present_b ? second_rst + 960 : read_from + 1120);
    send_item(owtr_pkg::OP_START, 1'($urandom_range(0, 1)));
    for (int k = 0; k < n_ticks; k++) begin
      if ($urandom_range(0, 199) == 0) send_item(owtr_pkg::OP_START, 1'($urandom_range(0, 1)));
      lvl = 1'($urandom_range(0, 1));
      if (k == 550) lvl = !present_a;
      if (k == second_rst + 550) lvl = !present_b;
      if (k >= read_from && (k - read_from) % 70 == 15) lvl = temp[(k - read_from) / 70];
      send_item(owtr_pkg::OP_TICK, lvl);
    end
    repeat ($urandom_range(0, 4)) send_item(owtr_pkg::OP_TICK, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [15:0] temp;
    int          pick;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= owtr_pkg::OP_TICK;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ticks, absent device under the reset wait, zero and one
    // tick of conversion wait, temperature extremes, absence at the second
    // reset and the widest wait.
    send_item(owtr_pkg::OP_TICK, 1'b0);
    send_item(owtr_pkg::OP_TICK, 1'b1);
    drive_temperature_read(1'b0, 1'b1, 16'h0000);
    set_conversion_wait(0);
    drive_temperature_read(1'b1, 1'b1, 16'h0000);
    drive_temperature_read(1'b1, 1'b1, 16'hFFFF);
    set_conversion_wait(1);
    drive_temperature_read(1'b1, 1'b1, 16'h8000);
    drive_temperature_read(1'b1, 1'b0, 16'h0191);
    set_conversion_wait(MAX_WAIT);
    drive_temperature_read(1'b0, 1'b0, 16'h0000);
    set_conversion_wait(37);
    drive_temperature_read(1'b1, 1'b1, 16'h7FFF);

    for (int n = 0; n < 3; n++) begin
      if (n % 3 == 0) begin
        pick = $urandom_range(0, 9);
        set_conversion_wait(pick == 0 ? 0 : pick == 1 ? 1 :
                            pick == 2 ? $urandom_range(2, 20) : $urandom_range(21, 1500));
      end
      pick = $urandom_range(0, 11);
      temp = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : (pick == 2) ? 16'hFFF0 :
             16'($urandom_range(0, 65535));
      drive_temperature_read($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, temp);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (n_failures == 0 && n_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
